[rtl/core/hcq_pkg.sv]
package hcq_pkg;

    localparam int COEFF_W        = 16;
    localparam int POS_W          = 16;
    localparam int STEP_W         = 7;
    localparam int BITS_PER_STAGE = 2;
    localparam int DIV_STAGES     = COEFF_W / BITS_PER_STAGE;
    localparam int PIPE_LATENCY   = DIV_STAGES + 2;

    localparam int LOW_BAND_EDGE_DEF = 16;
    localparam int ROW_SHIFT_DEF     = 8;

    localparam logic [COEFF_W-1:0] COEFF_MAX = {1'b0, {(COEFF_W-1){1'b1}}};

    typedef struct packed {
        logic               lowband;
        logic               neg;
        logic               last;
        logic [COEFF_W-1:0] coeff;
        logic [COEFF_W-1:0] mag;
    } t_tag;

    typedef struct packed {
        logic [COEFF_W-1:0] dvd;
        logic [STEP_W-1:0]  rem;
        t_tag               tag;
    } t_div_stage;

    function automatic logic [STEP_W-1:0] rem_step(
        input logic [STEP_W-1:0] rem,
        input logic              bit_in,
        input logic [STEP_W-1:0] step
    );
        logic [STEP_W:0] t;
        t = {rem, bit_in};
        if (t >= {1'b0, step}) begin
            t = t - {1'b0, step};
        end
        return t[STEP_W-1:0];
    endfunction

endpackage

[rtl/core/hcq_div_pipe.sv]
module hcq_div_pipe (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic [hcq_pkg::STEP_W-1:0] i_step,
    input  logic                   i_valid,
    input  hcq_pkg::t_tag          i_tag,
    output logic                   o_valid,
    output logic [hcq_pkg::STEP_W-1:0] o_rem,
    output hcq_pkg::t_tag          o_tag
);
    import hcq_pkg::*;

    t_div_stage                  w_cur [DIV_STAGES];
    t_div_stage                  n_stg [DIV_STAGES];
    t_div_stage                  r_stg [DIV_STAGES];
    logic [DIV_STAGES-1:0]       r_vld;

    for (genvar g = 0; g < DIV_STAGES; g++) begin : g_stage
        if (g == 0) begin : g_first
            assign w_cur[g] = '{dvd: i_tag.mag, rem: '0, tag: i_tag};
        end else begin : g_next
            assign w_cur[g] = r_stg[g-1];
        end

        always_comb begin
            logic [STEP_W-1:0]  rem;
            logic [COEFF_W-1:0] dvd;
            rem = w_cur[g].rem;
            dvd = w_cur[g].dvd;
            for (int k = 0; k < BITS_PER_STAGE; k++) begin
                rem = rem_step(rem, dvd[COEFF_W-1], i_step);
                dvd = {dvd[COEFF_W-2:0], 1'b0};
            end
            n_stg[g] = '{dvd: dvd, rem: rem, tag: w_cur[g].tag};
        end

        always_ff @(posedge i_clk) begin
            r_stg[g] <= n_stg[g];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            r_vld <= {r_vld[DIV_STAGES-2:0], i_valid};
        end
    end

    assign o_valid = r_vld[DIV_STAGES-1];
    assign o_rem   = r_stg[DIV_STAGES-1].rem;
    assign o_tag   = r_stg[DIV_STAGES-1].tag;

endmodule

[rtl/core/highband_coeff_quantizer.sv]
// Channel   Handshake        Payload
// request   start / busy     i_coeff, i_position, i_last_coeff
// result    o_valid strobe   o_quantized, o_last_out
// config    i_cfg_we         i_cfg_wdata (quant_step)
//
// One request per cycle; each result is registered through an input stage,
// eight remainder stages of two bits each and an output stage.
// Synchronous active-low reset clears all valid bits and quant_step;
// busy is high only during reset.
// The result side has no stall: the pipeline advances every cycle.
module highband_coeff_quantizer #(
    parameter int LOW_BAND_EDGE = hcq_pkg::LOW_BAND_EDGE_DEF,
    parameter int ROW_SHIFT     = hcq_pkg::ROW_SHIFT_DEF
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_cfg_we,
    input  logic [hcq_pkg::STEP_W-1:0]  i_cfg_wdata,
    input  logic                        start,
    output logic                        busy,
    input  logic [hcq_pkg::COEFF_W-1:0] i_coeff,
    input  logic [hcq_pkg::POS_W-1:0]   i_position,
    input  logic                        i_last_coeff,
    output logic                        o_valid,
    output logic [hcq_pkg::COEFF_W-1:0] o_quantized,
    output logic                        o_last_out
);
    import hcq_pkg::*;

    localparam int EDGE_W = POS_W + 1;
    localparam logic [EDGE_W-1:0] EDGE = EDGE_W'(LOW_BAND_EDGE);

    logic [STEP_W-1:0]  r_step;
    logic [STEP_W-1:0]  w_step_eff;
    logic [COEFF_W:0]   w_sum;
    logic [COEFF_W:0]   w_neg_sum;
    logic               w_accept;
    t_tag               n_fr_tag;
    t_tag               r_fr_tag;
    logic               r_fr_vld;

    logic               w_div_vld;
    logic [STEP_W-1:0]  w_div_rem;
    t_tag               w_div_tag;
    logic [COEFF_W-1:0] w_diff;
    logic [COEFF_W-1:0] n_quant;
    logic [COEFF_W-1:0] r_quant;
    logic               r_last;
    logic               r_vld;

    assign busy     = ~i_rst_n;
    assign w_accept = start & ~busy;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_step <= '0;
        end else if (i_cfg_we) begin
            r_step <= i_cfg_wdata;
        end
    end

    assign w_step_eff = (r_step == '0) ? STEP_W'(1) : r_step;
    assign w_sum      = {i_coeff[COEFF_W-1], i_coeff} + (COEFF_W+1)'(w_step_eff >> 1);
    assign w_neg_sum  = (COEFF_W+1)'(0) - w_sum;

    always_comb begin
        n_fr_tag.lowband = (EDGE_W'(i_position[ROW_SHIFT-1:0]) < EDGE)
                         && (EDGE_W'(i_position >> ROW_SHIFT) < EDGE);
        n_fr_tag.neg     = w_sum[COEFF_W];
        n_fr_tag.last    = i_last_coeff;
        n_fr_tag.coeff   = i_coeff;
        n_fr_tag.mag     = w_sum[COEFF_W] ? w_neg_sum[COEFF_W-1:0] : w_sum[COEFF_W-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fr_vld <= 1'b0;
        end else begin
            r_fr_vld <= w_accept;
        end
    end

    always_ff @(posedge i_clk) begin
        r_fr_tag <= n_fr_tag;
    end

    hcq_div_pipe u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_step  (w_step_eff),
        .i_valid (r_fr_vld),
        .i_tag   (r_fr_tag),
        .o_valid (w_div_vld),
        .o_rem   (w_div_rem),
        .o_tag   (w_div_tag)
    );

    assign w_diff = w_div_tag.mag - COEFF_W'(w_div_rem);

    always_comb begin
        priority if (w_div_tag.lowband) begin
            n_quant = w_div_tag.coeff;
        end else if (w_div_tag.neg) begin
            n_quant = COEFF_W'(0) - w_diff;
        end else if (w_diff > COEFF_MAX) begin
            n_quant = COEFF_MAX;
        end else begin
            n_quant = w_diff;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else begin
            r_vld <= w_div_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        r_quant <= n_quant;
        r_last  <= w_div_tag.last;
    end

    assign o_valid     = r_vld;
    assign o_quantized = r_quant;
    assign o_last_out  = r_last;

endmodule

[rtl/core/hcq_checker.sv]
module hcq_checker (
    input logic                        i_clk,
    input logic                        i_rst_n,
    input logic                        start,
    input logic                        busy,
    input logic                        i_last_coeff,
    input logic                        o_valid,
    input logic                        o_last_out
);
    import hcq_pkg::*;

    // every request yields a strobe after the fixed latency
    a_req_to_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |-> ##PIPE_LATENCY o_valid)
        else $error("request produced no result");

    // no strobe without a matching request
    a_result_has_req: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> $past(start && !busy, PIPE_LATENCY))
        else $error("result without request");

    // last flag travels with its item
    a_last_follows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |-> ##PIPE_LATENCY (o_last_out == $past(i_last_coeff, PIPE_LATENCY)))
        else $error("last flag mismatch");

    // busy only in reset
    a_busy_reset: assert property (@(posedge i_clk)
        busy == !i_rst_n)
        else $error("busy outside reset");

endmodule

bind highband_coeff_quantizer hcq_checker u_hcq_checker (.*);

[bench/highband_coeff_quantizer_test.sv]
module highband_coeff_quantizer_test;
    timeunit 1ns;
    timeprecision 1ps;

    import hcq_pkg::*;

    localparam int CLK_HALF       = 5;
    localparam int RESET_CYCLES   = 6;
    localparam int WATCHDOG_LIMIT = 1000;
    localparam int NUM_DIRECTED   = 23;
    localparam int NUM_PHASES     = 12;
    localparam int PHASE_ITEMS    = 150;
    localparam int PRESSURE_PHASE = 5;
    localparam int PRESSURE_ITEM  = 60;
    localparam int SAT_MAX        = 2 ** (COEFF_W - 1) - 1;
    localparam int SAT_MIN        = -(2 ** (COEFF_W - 1));

    typedef struct {
        logic [COEFF_W-1:0] quantized;
        logic               last_out;
    } t_qz_result;

    typedef struct {
        logic [STEP_W-1:0]  step;
        logic [COEFF_W-1:0] coeff;
        logic [POS_W-1:0]   position;
        logic               last;
        bit                 has_golden;
        logic [COEFF_W-1:0] golden;
    } t_stim_row;

    logic               i_clk = 1'b0;
    logic               i_rst_n;
    logic               i_cfg_we;
    logic [STEP_W-1:0]  i_cfg_wdata;
    logic               start;
    logic               busy;
    logic [COEFF_W-1:0] i_coeff;
    logic [POS_W-1:0]   i_position;
    logic               i_last_coeff;
    logic               o_valid;
    logic [COEFF_W-1:0] o_quantized;
    logic               o_last_out;

    logic               req_has_golden;
    logic [COEFF_W-1:0] req_golden;
    logic [STEP_W-1:0]  cur_step;
    t_qz_result         pending_q[$];
    int                 fail_count;
    int                 idle_cycles;

    t_stim_row directed_tbl [NUM_DIRECTED] = '{
        '{7'd0,   16'd12345, 16'h0010, 1'b0, 1'b1, 16'd12345},
        '{7'd0,   16'h8000,  16'hFFFF, 1'b1, 1'b1, 16'h8000},
        '{7'd0,   16'h7FFF,  16'h1000, 1'b0, 1'b1, 16'h7FFF},
        '{7'd1,   16'hFFFF,  16'h1234, 1'b1, 1'b1, 16'hFFFF},
        '{7'd5,   16'd7,     16'h0F0F, 1'b0, 1'b1, 16'd7},
        '{7'd5,   16'h8000,  16'h0000, 1'b1, 1'b1, 16'h8000},
        '{7'd5,   16'h7FFF,  16'h000F, 1'b0, 1'b1, 16'h7FFF},
        '{7'd5,   16'd7,     16'h0F10, 1'b0, 1'b0, 16'd0},
        '{7'd5,   16'hFFF9,  16'h00FF, 1'b1, 1'b0, 16'd0},
        '{7'd2,   16'd3,     16'h0100, 1'b0, 1'b0, 16'd0},
        '{7'd2,   16'hFFFD,  16'h0100, 1'b0, 1'b0, 16'd0},
        '{7'd64,  16'h7FFF,  16'hFFFF, 1'b0, 1'b1, 16'h7FFF},
        '{7'd100, 16'h7FFF,  16'h8000, 1'b1, 1'b1, 16'h7FFF},
        '{7'd100, 16'h8000,  16'h0100, 1'b0, 1'b0, 16'd0},
        '{7'd100, 16'd0,     16'hFF0F, 1'b0, 1'b1, 16'd0},
        '{7'd100, 16'd49,    16'h0020, 1'b0, 1'b0, 16'd0},
        '{7'd100, 16'd50,    16'h0020, 1'b1, 1'b0, 16'd0},
        '{7'd101, 16'h7FFF,  16'h0F10, 1'b0, 1'b0, 16'd0},
        '{7'd127, 16'h7FFF,  16'h1010, 1'b0, 1'b0, 16'd0},
        '{7'd127, 16'h8000,  16'hF00F, 1'b1, 1'b0, 16'd0},
        '{7'd127, 16'hFFC1,  16'h00F0, 1'b0, 1'b0, 16'd0},
        '{7'd127, 16'h5555,  16'h0F0F, 1'b0, 1'b1, 16'h5555},
        '{7'd1,   16'hAAAA,  16'h5555, 1'b1, 1'b1, 16'hAAAA}
    };

    highband_coeff_quantizer u_dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_wdata  (i_cfg_wdata),
        .start        (start),
        .busy         (busy),
        .i_coeff      (i_coeff),
        .i_position   (i_position),
        .i_last_coeff (i_last_coeff),
        .o_valid      (o_valid),
        .o_quantized  (o_quantized),
        .o_last_out   (o_last_out)
    );

    always #CLK_HALF i_clk = ~i_clk;

    function automatic t_qz_result quantize_coeff(
        input logic [COEFF_W-1:0] coeff,
        input logic [POS_W-1:0]   position,
        input logic               last,
        input logic [STEP_W-1:0]  step
    );
        t_qz_result res;
        int         c;
        int         s;
        int         q;
        int         r;
        int         col;
        int         row;
        c   = int'($signed(coeff));
        col = int'(position) & ((1 << ROW_SHIFT_DEF) - 1);
        row = int'(position) >> ROW_SHIFT_DEF;
        r   = c;
        if (!(col < LOW_BAND_EDGE_DEF && row < LOW_BAND_EDGE_DEF)) begin
            s = (step == '0) ? 1 : int'(step);
            q = (c + s / 2) / s;
            r = q * s;
            if (r > SAT_MAX) r = SAT_MAX;
            if (r < SAT_MIN) r = SAT_MIN;
        end
        res.quantized = r[COEFF_W-1:0];
        res.last_out  = last;
        return res;
    endfunction

    always @(posedge i_clk) begin : result_check
        t_qz_result head;
        if (o_valid) begin
            if (pending_q.size() == 0) begin
                $error("quantized: expected none, got %0d", $signed(o_quantized));
                fail_count++;
            end else begin
                head = pending_q.pop_front();
                if (o_quantized !== head.quantized) begin
                    $error("quantized: expected %0d, got %0d",
                           $signed(head.quantized), $signed(o_quantized));
                    fail_count++;
                end
                if (o_last_out !== head.last_out) begin
                    $error("last_out: expected %0b, got %0b", head.last_out, o_last_out);
                    fail_count++;
                end
            end
        end
        if (start && !busy) begin
            if (req_has_golden) begin
                head.quantized = req_golden;
                head.last_out  = i_last_coeff;
            end else begin
                head = quantize_coeff(i_coeff, i_position, i_last_coeff, cur_step);
            end
            pending_q.push_back(head);
        end
    end

    always @(posedge i_clk) begin
        if ((start && !busy) || o_valid) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("simulation failed");
            $finish;
        end
    end

    task automatic wait_drained();
        start <= 1'b0;
        @(posedge i_clk);
        while (pending_q.size() != 0) @(posedge i_clk);
    endtask

    task automatic set_step(input logic [STEP_W-1:0] step);
        wait_drained();
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= step;
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
        cur_step     = step;
    endtask

    task automatic send_request(
        input logic [COEFF_W-1:0] coeff,
        input logic [POS_W-1:0]   position,
        input logic               last,
        input bit                 has_golden,
        input logic [COEFF_W-1:0] golden,
        input bit                 allow_gap
    );
        start          <= 1'b1;
        i_coeff        <= coeff;
        i_position     <= position;
        i_last_coeff   <= last;
        req_has_golden <= has_golden;
        req_golden     <= golden;
        do @(posedge i_clk); while (busy);
        if (allow_gap && $urandom_range(0, 3) == 0) begin
            start <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge i_clk);
        end
    endtask

    function automatic logic [COEFF_W-1:0] rand_coeff();
        case ($urandom_range(0, 7))
            0: return COEFF_W'(16'h8000 + $urandom_range(0, 127));
            1: return COEFF_W'(16'h7FFF - $urandom_range(0, 127));
            2: return COEFF_W'($urandom_range(0, 255) - 128);
            default: return COEFF_W'($urandom);
        endcase
    endfunction

    function automatic logic [POS_W-1:0] rand_position();
        case ($urandom_range(0, 3))
            0: return POS_W'(($urandom_range(0, 15) << ROW_SHIFT_DEF) | $urandom_range(0, 15));
            1: return POS_W'(($urandom_range(15, 16) << ROW_SHIFT_DEF) | $urandom_range(15, 16));
            default: return POS_W'($urandom);
        endcase
    endfunction

    initial begin
        logic [STEP_W-1:0] step;
        i_rst_n        <= 1'b0;
        i_cfg_we       <= 1'b0;
        i_cfg_wdata    <= '0;
        start          <= 1'b0;
        i_coeff        <= '0;
        i_position     <= '0;
        i_last_coeff   <= 1'b0;
        req_has_golden <= 1'b0;
        req_golden     <= '0;
        cur_step        = '0;
        fail_count      = 0;
        idle_cycles     = 0;
        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        for (int i = 0; i < NUM_DIRECTED; i++) begin
            if (directed_tbl[i].step != cur_step) set_step(directed_tbl[i].step);
            send_request(directed_tbl[i].coeff, directed_tbl[i].position,
                         directed_tbl[i].last, directed_tbl[i].has_golden,
                         directed_tbl[i].golden, 1'b1);
        end

        for (int p = 0; p < NUM_PHASES; p++) begin
            case (p)
                0: step = 7'd127;
                1: step = 7'd0;
                2: step = 7'd100;
                3: step = 7'd1;
                4: step = 7'd2;
                5: step = 7'd101;
                NUM_PHASES - 1: step = 7'd64;
                default: step = STEP_W'($urandom_range(0, 127));
            endcase
            set_step(step);
            for (int n = 0; n < PHASE_ITEMS; n++) begin
                if (p == PRESSURE_PHASE && n == PRESSURE_ITEM) wait_drained();
                send_request(rand_coeff(), rand_position(), $urandom_range(0, 7) == 0,
                             1'b0, '0, p < NUM_PHASES - 2);
            end
        end

        wait_drained();
        repeat (PIPE_LATENCY + 2) @(posedge i_clk);
        if (pending_q.size() != 0) begin
            $error("quantized: %0d results still pending", pending_q.size());
            fail_count++;
        end
        if (fail_count == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule
